FILE: src/ccdp_pkg.sv
// Shared types and constants of the complex conjugate dot product core.
// Sample and accumulator widths, beat structs of both channels and the queue entry.
// No dependencies.
package ccdp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = 48;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int TERM_BITS   = PROD_BITS + 1;
	localparam int SUM_BITS    = ((ACC_BITS > TERM_BITS) ? ACC_BITS : TERM_BITS) + 1;

	localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x_re;
		logic signed [SAMPLE_BITS-1:0] x_im;
		logic signed [SAMPLE_BITS-1:0] y_re;
		logic signed [SAMPLE_BITS-1:0] y_im;
		logic                          last_element;
	} elem_beat_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] dot_re;
		logic signed [ACC_BITS-1:0] dot_im;
		logic                       saturated;
	} dot_beat_t;

	typedef struct packed {
		logic signed [TERM_BITS-1:0] term_re;
		logic signed [TERM_BITS-1:0] term_im;
		logic                        last;
	} term_t;

endpackage

FILE: src/ccdp_front.sv
// Front end: takes element beats and forms the exact conj(x)*y terms.
// One registered multiply stage, then the term sums toward the queue.
// Depends on ccdp_pkg.
module ccdp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ccdp_pkg::elem_beat_t elem,
	input  logic                elem_valid,
	output logic                elem_stall,
	output ccdp_pkg::term_t     term,
	output logic                term_valid,
	input  logic                term_ready
);
	import ccdp_pkg::*;

	logic                        valid_s1;
	logic                        last_s1;
	logic signed [PROD_BITS-1:0] prod_rr_s1;
	logic signed [PROD_BITS-1:0] prod_ii_s1;
	logic signed [PROD_BITS-1:0] prod_ri_s1;
	logic signed [PROD_BITS-1:0] prod_ir_s1;

	assign elem_stall = valid_s1 && !term_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!elem_stall) begin
			valid_s1 <= elem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_valid && !elem_stall) begin
			prod_rr_s1 <= elem.x_re * elem.y_re;
			prod_ii_s1 <= elem.x_im * elem.y_im;
			prod_ri_s1 <= elem.x_re * elem.y_im;
			prod_ir_s1 <= elem.x_im * elem.y_re;
			last_s1    <= elem.last_element;
		end
	end

	assign term_valid   = valid_s1;
	assign term.term_re = TERM_BITS'(prod_rr_s1) + TERM_BITS'(prod_ii_s1);
	assign term.term_im = TERM_BITS'(prod_ri_s1) - TERM_BITS'(prod_ir_s1);
	assign term.last    = last_s1;

endmodule

FILE: src/ccdp_queue.sv
// Short term queue between the multiply front end and the accumulator.
// Register array with write and read pointers and an occupancy count.
// Depends on ccdp_pkg.
module ccdp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ccdp_pkg::term_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output ccdp_pkg::term_t head,
	output logic            head_valid,
	input  logic            pop
);
	import ccdp_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	term_t               entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push;

	assign push_ready = (count_q != CNT_BITS'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/ccdp_back.sv
// Back end: saturating accumulation of queued terms and the result register.
// Emits one dot beat per vector and clears the accumulators on the last term.
// Depends on ccdp_pkg.
module ccdp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ccdp_pkg::term_t     head,
	input  logic                head_valid,
	output logic                pop,
	output ccdp_pkg::dot_beat_t dot,
	output logic                dot_valid,
	input  logic                dot_stall
);
	import ccdp_pkg::*;

	typedef struct packed {
		logic                       sat;
		logic signed [ACC_BITS-1:0] value;
	} acc_upd_t;

	logic signed [ACC_BITS-1:0] acc_re_q;
	logic signed [ACC_BITS-1:0] acc_im_q;
	logic                       sat_q;
	logic                       dot_valid_q;
	dot_beat_t                  dot_q;
	logic signed [SUM_BITS-1:0] sum_re;
	logic signed [SUM_BITS-1:0] sum_im;
	acc_upd_t                   upd_re;
	acc_upd_t                   upd_im;
	logic                       sat_any;

	function automatic acc_upd_t clamp(input logic signed [SUM_BITS-1:0] s);
		logic signed [ACC_BITS-1:0] lo;
		acc_upd_t                   r;
		lo = s[ACC_BITS-1:0];
		if (s == SUM_BITS'(lo)) begin
			r.sat   = 1'b0;
			r.value = lo;
		end else begin
			r.sat   = 1'b1;
			r.value = s[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

	assign sum_re  = SUM_BITS'(acc_re_q) + SUM_BITS'(head.term_re);
	assign sum_im  = SUM_BITS'(acc_im_q) + SUM_BITS'(head.term_im);
	assign upd_re  = clamp(sum_re);
	assign upd_im  = clamp(sum_im);
	assign sat_any = sat_q || upd_re.sat || upd_im.sat;

	// a last term needs a free result register
	assign pop = head_valid && (!head.last || !dot_valid_q || !dot_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			sat_q       <= 1'b0;
			dot_valid_q <= 1'b0;
		end else begin
			if (pop && head.last) begin
				dot_valid_q <= 1'b1;
			end else if (!dot_stall) begin
				dot_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
					sat_q    <= 1'b0;
				end else begin
					acc_re_q <= upd_re.value;
					acc_im_q <= upd_im.value;
					sat_q    <= sat_any;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			dot_q.dot_re    <= upd_re.value;
			dot_q.dot_im    <= upd_im.value;
			dot_q.saturated <= sat_any;
		end
	end

	assign dot       = dot_q;
	assign dot_valid = dot_valid_q;

endmodule

FILE: src/complex_conj_dot_product_core.sv
// Top level of the complex conjugate dot product core.
// Ties the multiply front end, the term queue and the accumulator back end.
// Depends on ccdp_pkg, ccdp_front, ccdp_queue, ccdp_back.

// Streams element pairs (x, y) in Q1.15 and sums conj(x)*y into two saturating
// 48-bit Q18.30 accumulators. One element beat is taken each unstalled cycle; a
// beat with last_element set yields one dot beat holding the total (its own term
// included) and the sticky saturation flag, then the accumulators restart from
// zero. Throughput is one element per unstalled clock, set by the single complex
// multiply stage and the accumulate loop. The last element passes the multiply,
// queue and result registers to its dot beat. The queue of QUEUE_DEPTH terms lets
// elements keep flowing while a result waits on dot_stall.
module complex_conj_dot_product_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccdp_pkg::elem_beat_t elem,
	input  logic                 elem_valid,
	output logic                 elem_stall,
	output ccdp_pkg::dot_beat_t  dot,
	output logic                 dot_valid,
	input  logic                 dot_stall
);
	import ccdp_pkg::*;

	term_t term;
	logic  term_valid;
	logic  term_ready;
	term_t head;
	logic  head_valid;
	logic  pop;

	ccdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem       (elem),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.term       (term),
		.term_valid (term_valid),
		.term_ready (term_ready)
	);

	ccdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (term),
		.push_valid (term_valid),
		.push_ready (term_ready),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	ccdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.dot        (dot),
		.dot_valid  (dot_valid),
		.dot_stall  (dot_stall)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		elem_stall |-> (term_valid && !term_ready))
		else $error("element stall without a full queue");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!term_ready |-> head_valid)
		else $error("queue full and empty at once");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dot_valid) |-> $past(pop && head.last))
		else $error("dot beat without a last term");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench of complex_conj_dot_product_core: directed and random element beats.
// Checks every dot beat against an in-bench saturating conj(x)*y accumulator.
// Depends on ccdp_pkg and the core RTL.
module testbench;
	import ccdp_pkg::*;

	localparam int HALF_NS = 2;
	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_PER_PHASE = 250;
	localparam longint TIMEOUT_NS = 64'd8_000_000;
	localparam longint ACC_HI = (64'sd1 <<< (ACC_BITS - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_ONE = {{(SAMPLE_BITS-1){1'b0}}, 1'b1};

	typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

	typedef struct {
		elem_beat_t beat;
		phase_e     phase;
		bit         drain_first;
		bit         hold_rx;
	} feed_t;

	logic clk = 1'b0;
	logic arst_n;
	elem_beat_t elem = '0;
	logic elem_valid = 1'b0;
	logic elem_stall;
	dot_beat_t dot;
	logic dot_valid;
	logic dot_stall = 1'b0;

	feed_t feed_q[$];
	dot_beat_t expected_dots[$];
	logic signed [ACC_BITS-1:0] run_re = '0;
	logic signed [ACC_BITS-1:0] run_im = '0;
	bit run_sat = 1'b0;

	phase_e gen_phase = PH_STEADY;
	bit gen_drain = 1'b0;
	bit gen_hold = 1'b0;
	phase_e cur_phase = PH_STEADY;
	int dots_due = 0;
	int dots_seen = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;

	complex_conj_dot_product_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem       (elem),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.dot        (dot),
		.dot_valid  (dot_valid),
		.dot_stall  (dot_stall)
	);

	always #(HALF_NS) clk = ~clk;

	function automatic int send_idle_pct(input phase_e ph);
		case (ph)
			PH_SEND_IDLE: return 60;
			PH_BOTH: return 9;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input phase_e ph);
		case (ph)
			PH_RECV_STALL: return 60;
			PH_BOTH: return 9;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [ACC_BITS-1:0] clamp_acc(input longint v, inout bit hit);
		if (v > ACC_HI) begin
			hit = 1'b1;
			return ACC_MAX;
		end
		if (v < ACC_LO) begin
			hit = 1'b1;
			return ACC_MIN;
		end
		return v[ACC_BITS-1:0];
	endfunction

	// Adds conj(x)*y of one beat; on the closing beat queues the dot beat and clears.
	function automatic bit conj_mac(input elem_beat_t b);
		longint xr, xi, yr, yi, term_re, term_im;
		bit hit;
		dot_beat_t d;
		xr = b.x_re;
		xi = b.x_im;
		yr = b.y_re;
		yi = b.y_im;
		hit = 1'b0;
		term_re = xr * yr + xi * yi;
		term_im = xr * yi - xi * yr;
		run_re = clamp_acc(longint'(run_re) + term_re, hit);
		run_im = clamp_acc(longint'(run_im) + term_im, hit);
		run_sat = run_sat | hit;
		if (!b.last_element)
			return 1'b0;
		d.dot_re = run_re;
		d.dot_im = run_im;
		d.saturated = run_sat;
		expected_dots.push_back(d);
		run_re = '0;
		run_im = '0;
		run_sat = 1'b0;
		return 1'b1;
	endfunction

	function automatic bit ready_to_send(input int due);
		if (feed_q[0].drain_first && due != dots_seen)
			return 1'b0;
		return $urandom_range(99) >= send_idle_pct(feed_q[0].phase);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, 30);
		return $urandom_range(31, 100);
	endfunction

	task automatic add_elem(input logic signed [SAMPLE_BITS-1:0] xr, xi, yr, yi,
			input logic is_last);
		feed_t f;
		f.beat.x_re = xr;
		f.beat.x_im = xi;
		f.beat.y_re = yr;
		f.beat.y_im = yi;
		f.beat.last_element = is_last;
		f.phase = gen_phase;
		f.drain_first = gen_drain;
		f.hold_rx = gen_hold;
		gen_drain = 1'b0;
		gen_hold = 1'b0;
		feed_q.push_back(f);
	endtask

	task automatic add_random_phase(input phase_e ph, input int count);
		int n, len;
		gen_phase = ph;
		n = 0;
		while (n < count) begin
			len = pick_len();
			for (int i = 0; i < len; i++)
				add_elem(pick_sample(), pick_sample(), pick_sample(), pick_sample(), i == len - 1);
			n += len;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drive_elems
		int due;
		if (!arst_n) begin
			elem <= '0;
			elem_valid <= 1'b0;
			cur_phase <= PH_STEADY;
			dots_due <= 0;
			hold_seq <= 0;
		end else begin
			due = dots_due;
			if (elem_valid && !elem_stall) begin
				if (conj_mac(elem))
					due = due + 1;
			end
			dots_due <= due;
			if (!elem_valid || !elem_stall) begin
				if (feed_q.size() != 0 && ready_to_send(due)) begin
					elem <= feed_q[0].beat;
					elem_valid <= 1'b1;
					cur_phase <= feed_q[0].phase;
					if (feed_q[0].hold_rx)
						hold_seq <= hold_seq + 1;
					void'(feed_q.pop_front());
				end else begin
					elem_valid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_stall <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			dot_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dot_stall <= 1'b1;
		end else begin
			dot_stall <= $urandom_range(99) < recv_stall_pct(cur_phase);
		end
	end

	// dot beat checker
	always @(posedge clk or negedge arst_n) begin : check_dots
		dot_beat_t want;
		if (!arst_n) begin
			dots_seen <= 0;
		end else if (dot_valid && !dot_stall) begin
			dots_seen <= dots_seen + 1;
			if (expected_dots.size() == 0) begin
				mismatches++;
				$display("%0t dot beat expected none, got re %0d im %0d sat %0b",
					$time, dot.dot_re, dot.dot_im, dot.saturated);
			end else begin
				want = expected_dots.pop_front();
				if (dot.dot_re !== want.dot_re) begin
					mismatches++;
					$display("%0t dot_re expected %0d got %0d", $time, want.dot_re, dot.dot_re);
				end
				if (dot.dot_im !== want.dot_im) begin
					mismatches++;
					$display("%0t dot_im expected %0d got %0d", $time, want.dot_im, dot.dot_im);
				end
				if (dot.saturated !== want.saturated) begin
					mismatches++;
					$display("%0t saturated expected %0b got %0b",
						$time, want.saturated, dot.saturated);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// directed: extremes, bit patterns, single and multi element vectors
		gen_phase = PH_BOTH;
		add_elem('0, '0, '0, '0, 1'b1);
		add_elem(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1);
		add_elem(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
		add_elem(S_MAX, S_MIN, S_MIN, S_MIN, 1'b1);
		add_elem(S_MIN, S_MAX, S_MAX, S_MIN, 1'b1);
		add_elem(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);
		add_elem('1, '1, '1, '1, 1'b1);
		add_elem(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1);
		add_elem(S_ONE, '0, S_ONE, '0, 1'b0);
		add_elem('0, S_ONE, '0, S_ONE, 1'b0);
		add_elem('1, '1, S_MAX, S_MAX, 1'b0);
		add_elem(S_MAX, S_MAX, S_MIN, S_MIN, 1'b1);
		add_elem(S_MIN, '0, '0, S_MIN, 1'b0);
		add_elem('0, S_MIN, S_MIN, '0, 1'b0);
		add_elem(S_MAX, '1, S_ONE, S_MIN, 1'b1);

		gen_hold = 1'b1;
		add_random_phase(PH_STEADY, RANDOM_PER_PHASE);
		gen_drain = 1'b1;
		add_random_phase(PH_SEND_IDLE, RANDOM_PER_PHASE);
		add_random_phase(PH_RECV_STALL, RANDOM_PER_PHASE);
		add_random_phase(PH_BOTH, RANDOM_PER_PHASE);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (feed_q.size() != 0 || elem_valid || dots_due != dots_seen);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (expected_dots.size() != 0)
			$display("%0t %0d dot beats expected, none seen", $time, expected_dots.size());
		if (mismatches == 0 && expected_dots.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
